@@ design/fft_pkg.sv @@
// Shared sizes and the twiddle table of the fixed-point radix-2 FFT.
// Used by the FFT top level; no dependencies.
package fft_pkg;

   localparam int POINTS_LOG2  = 6;
   localparam int POINTS       = 1 << POINTS_LOG2;
   localparam int HALF_POINTS  = POINTS / 2;
   localparam int ADDR_W       = POINTS_LOG2;
   localparam int BFLY_W       = POINTS_LOG2 - 1;
   localparam int STAGE_W      = $clog2(POINTS_LOG2);
   localparam int SAMPLE_W     = 11;
   localparam int BIN_W        = 12;
   localparam int WORD_W       = 16;
   localparam int ENTRY_W      = 2 * WORD_W;

   localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 11'd1024;
   localparam int                  Q_ONE        = 32767;
   localparam int                  Q_SHIFT      = 15;

   localparam int STEP_COS [16] = '{
      32767, -32767, 0, 23170, 30273, 32138, 32610, 32729,
      32758, 32766, 32767, 32767, 32767, 32767, 32767, 32767
   };
   localparam int STEP_SIN [16] = '{
      0, 0, 32767, 23170, 12539, 6393, 3212, 1608,
      804, 402, 201, 100, 50, 25, 13, 6
   };

   typedef struct packed {
      logic signed [WORD_W-1:0] cos_val;
      logic signed [WORD_W-1:0] sin_val;
   } twiddle_type;

   typedef twiddle_type [HALF_POINTS-1:0] twiddle_table_type;

   // Rotation recurrence, truncated at every step; only the first half is ever used.
   function automatic twiddle_table_type build_twiddle_table();
      twiddle_table_type tbl;
      int cd;
      int sd;
      int cr;
      int sr;
      int cn;
      int sn;
      cd = STEP_COS[POINTS_LOG2 & 15];
      sd = STEP_SIN[POINTS_LOG2 & 15];
      cr = Q_ONE;
      sr = 0;
      for (int k = 0; k < HALF_POINTS; k++) begin
         tbl[k].cos_val = cr[WORD_W-1:0];
         tbl[k].sin_val = sr[WORD_W-1:0];
         cn = ((cr * cd) >>> Q_SHIFT) - ((sr * sd) >>> Q_SHIFT);
         sn = ((sr * cd) >>> Q_SHIFT) + ((cr * sd) >>> Q_SHIFT);
         cr = cn;
         sr = sn;
      end
      return tbl;
   endfunction

   localparam twiddle_table_type TWIDDLE_TABLE = build_twiddle_table();

endpackage

@@ design/fft_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module fft_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
   output logic [DATA_WIDTH-1:0]         rd_data_a,
   output logic [DATA_WIDTH-1:0]         rd_data_b
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_a_ff;
   logic [DATA_WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ design/fixed_point_radix2_fft_unit.sv @@
// Top level of the fixed-point radix-2 FFT: frame load, in-place butterflies, bin readout.
// Depends on fft_pkg and fft_ram.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_sample
//   rsp      out        rsp_valid/rsp_ready    rsp_bin_real, rsp_bin_imag, rsp_last_bin
//   csr      in         csr_valid/csr_ready    csr_input_offset
//
// Samples load one a cycle while req_ready is high, at bit-reversed work RAM addresses.
// Each butterfly of the transform steps through a RAM read, a multiply and two write-backs
// through the single write port; readout reads and registers each bin, then holds it until taken.
// Synchronous reset clears control and sets the offset to 1024; no RAM clearing pass.
// req_ready is low during transform and readout; rsp back-pressure simply holds the bin.
module fixed_point_radix2_fft_unit
   import fft_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_W-1:0]       req_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [BIN_W-1:0]   rsp_bin_real,
   output logic signed [BIN_W-1:0]   rsp_bin_imag,
   output logic                      rsp_last_bin,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SAMPLE_W-1:0]       csr_input_offset
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BF_READ,
      ST_BF_MUL,
      ST_BF_WRP,
      ST_BF_WRQ,
      ST_OUT_READ,
      ST_OUT_LOAD,
      ST_OUT_WAIT
   } state_type;

   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(POINTS_LOG2 - 1);
   localparam int                 PROD_W     = WORD_W + 1 + WORD_W + 1;
   localparam int                 SCALED_W   = PROD_W - Q_SHIFT;

   state_type                   state_ff;
   logic [SAMPLE_W-1:0]         offset_ff;
   logic [ADDR_W-1:0]           index_ff;
   logic [BFLY_W-1:0]           bfly_ff;
   logic [STAGE_W-1:0]          stage_ff;
   twiddle_type                 twiddle_ff;
   logic signed [SCALED_W-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [ENTRY_W-1:0]          u_ff;
   logic [ENTRY_W-1:0]          q_word_ff;
   logic                        rsp_valid_ff;
   logic signed [BIN_W-1:0]     rsp_real_ff, rsp_imag_ff;
   logic                        rsp_last_ff;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr_a, rd_addr_b;
   logic [ENTRY_W-1:0]          wr_data, rd_data_a, rd_data_b;

   logic [ADDR_W-1:0]           low_mask, bfly_ext, addr_p, addr_q, tw_full;
   logic [BFLY_W-1:0]           tw_index;
   logic signed [11:0]          centered;
   logic signed [WORD_W-1:0]    vr, vi, ur, ui;
   logic signed [WORD_W:0]      wr, wi;
   logic signed [PROD_W-1:0]    m_rr, m_ii, m_ri, m_ir;
   logic signed [SCALED_W:0]    t_re, t_im;
   logic signed [SCALED_W+1:0]  sum_re, sum_im, dif_re, dif_im;
   logic                        req_fire, rsp_fire;

   function automatic logic [ADDR_W-1:0] mirror_addr(input logic [ADDR_W-1:0] x);
      logic [ADDR_W-1:0] r;
      for (int b = 0; b < ADDR_W; b++) begin
         r[b] = x[ADDR_W-1-b];
      end
      return r;
   endfunction

   function automatic logic signed [BIN_W-1:0] saturate(input logic signed [WORD_W-1:0] v);
      logic signed [BIN_W-1:0] r;
      if (v > WORD_W'(2047)) begin
         r = 12'sd2047;
      end else if (v < -WORD_W'(2048)) begin
         r = -12'sd2048;
      end else begin
         r = v[BIN_W-1:0];
      end
      return r;
   endfunction

   assign req_ready = (state_ff == ST_LOAD);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // butterfly addressing: p has a zero inserted at bit 'stage', q sets it
   always_comb begin
      low_mask = (ADDR_W'(1) << stage_ff) - ADDR_W'(1);
      bfly_ext = {1'b0, bfly_ff};
      addr_p   = ((bfly_ext & ~low_mask) << 1) | (bfly_ext & low_mask);
      addr_q   = addr_p | (ADDR_W'(1) << stage_ff);
      tw_full  = (bfly_ext & low_mask) << (LAST_STAGE - stage_ff);
      tw_index = tw_full[BFLY_W-1:0];
   end

   assign centered = signed'({1'b0, req_sample}) - signed'({1'b0, offset_ff});

   assign vr = rd_data_b[ENTRY_W-1:WORD_W];
   assign vi = rd_data_b[WORD_W-1:0];
   assign wr = (WORD_W+1)'(twiddle_ff.cos_val);
   assign wi = (WORD_W+1)'(0) - (WORD_W+1)'(twiddle_ff.sin_val);
   assign m_rr = PROD_W'(vr) * PROD_W'(wr);
   assign m_ii = PROD_W'(vi) * PROD_W'(wi);
   assign m_ri = PROD_W'(vr) * PROD_W'(wi);
   assign m_ir = PROD_W'(vi) * PROD_W'(wr);

   assign ur     = u_ff[ENTRY_W-1:WORD_W];
   assign ui     = u_ff[WORD_W-1:0];
   assign t_re   = (SCALED_W+1)'(p_rr_ff) - (SCALED_W+1)'(p_ii_ff);
   assign t_im   = (SCALED_W+1)'(p_ri_ff) + (SCALED_W+1)'(p_ir_ff);
   assign sum_re = (SCALED_W+2)'(ur) + (SCALED_W+2)'(t_re);
   assign sum_im = (SCALED_W+2)'(ui) + (SCALED_W+2)'(t_im);
   assign dif_re = (SCALED_W+2)'(ur) - (SCALED_W+2)'(t_re);
   assign dif_im = (SCALED_W+2)'(ui) - (SCALED_W+2)'(t_im);

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = addr_p;
      wr_data   = {sum_re[WORD_W:1], sum_im[WORD_W:1]};
      rd_addr_a = addr_p;
      rd_addr_b = addr_q;
      unique case (state_ff)
         ST_LOAD: begin
            wr_en   = req_fire;
            wr_addr = mirror_addr(index_ff);
            wr_data = {{(WORD_W-12){centered[11]}}, centered, WORD_W'(0)};
         end
         ST_BF_WRP: begin
            wr_en = 1'b1;
         end
         ST_BF_WRQ: begin
            wr_en   = 1'b1;
            wr_addr = addr_q;
            wr_data = q_word_ff;
         end
         ST_OUT_READ, ST_OUT_LOAD, ST_OUT_WAIT: begin
            rd_addr_a = index_ff;
         end
         default: begin
         end
      endcase
   end

   fft_ram #(
      .DATA_WIDTH (ENTRY_W),
      .DEPTH      (POINTS)
   ) u_work_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         offset_ff    <= OFFSET_RESET;
         index_ff     <= '0;
         bfly_ff      <= '0;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            offset_ff <= csr_input_offset;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  index_ff <= index_ff + ADDR_W'(1);
                  if (&index_ff) begin
                     state_ff <= ST_BF_READ;
                  end
               end
            end
            ST_BF_READ: begin
               twiddle_ff <= TWIDDLE_TABLE[tw_index];
               state_ff   <= ST_BF_MUL;
            end
            ST_BF_MUL: begin
               p_rr_ff  <= SCALED_W'(m_rr >>> Q_SHIFT);
               p_ii_ff  <= SCALED_W'(m_ii >>> Q_SHIFT);
               p_ri_ff  <= SCALED_W'(m_ri >>> Q_SHIFT);
               p_ir_ff  <= SCALED_W'(m_ir >>> Q_SHIFT);
               u_ff     <= rd_data_a;
               state_ff <= ST_BF_WRP;
            end
            ST_BF_WRP: begin
               q_word_ff <= {dif_re[WORD_W:1], dif_im[WORD_W:1]};
               state_ff  <= ST_BF_WRQ;
            end
            ST_BF_WRQ: begin
               bfly_ff  <= bfly_ff + BFLY_W'(1);
               state_ff <= ST_BF_READ;
               if (&bfly_ff) begin
                  if (stage_ff == LAST_STAGE) begin
                     stage_ff <= '0;
                     state_ff <= ST_OUT_READ;
                  end else begin
                     stage_ff <= stage_ff + STAGE_W'(1);
                  end
               end
            end
            ST_OUT_READ: begin
               state_ff <= ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
               rsp_real_ff  <= saturate(rd_data_a[ENTRY_W-1:WORD_W]);
               rsp_imag_ff  <= saturate(rd_data_a[WORD_W-1:0]);
               rsp_last_ff  <= &index_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
               if (rsp_fire) begin
                  rsp_valid_ff <= 1'b0;
                  index_ff     <= index_ff + ADDR_W'(1);
                  state_ff     <= (&index_ff) ? ST_LOAD : ST_OUT_READ;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_bin_real = rsp_real_ff;
   assign rsp_bin_imag = rsp_imag_ff;
   assign rsp_last_bin = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a bin is pending");

   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT_WAIT))
      else $error("bin valid outside readout");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (&index_ff))
      else $error("last bin flagged at wrong index");

   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_ff) |=> (req_ready && (index_ff == '0)))
      else $error("no return to loading after final bin");
`endif

endmodule
